>>> rtl/rgb9e5_shared_exponent_pack_top_defines.svh
// Assertion macros shared by the checker.
`ifndef RGB9E5_SHARED_EXPONENT_PACK_TOP_DEFINES_SVH
`define RGB9E5_SHARED_EXPONENT_PACK_TOP_DEFINES_SVH
`define RGB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/rgb9e5_pkg.sv
package rgb9e5_pkg;
  typedef struct packed {
    logic        zero;
    logic [23:0] m;
    logic [9:0]  e;
  } chan_t;

  typedef struct packed {
    logic [2:0]  zero;
    logic [71:0] m;
    logic [29:0] e;
  } lanes_t;
endpackage

>>> rtl/rgb9e5_decode.sv
module rgb9e5_decode
  import rgb9e5_pkg::*;
#(
  parameter int MANTISSA_WIDTH = 9,
  parameter int EXPONENT_BIAS = 15,
  parameter int MAX_BIASED_EXPONENT = 31
) (
  input  logic [31:0] bits_i,
  output chan_t       chan_o
);
  localparam int MaxE = MAX_BIASED_EXPONENT - EXPONENT_BIAS - 24;
  localparam logic [23:0] MaxM = 24'(((1 << MANTISSA_WIDTH) - 1) << (24 - MANTISSA_WIDTH));
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [4:0]  lz;
  logic [23:0] m;
  logic signed [9:0] e;
  logic zero;

  always_comb begin
    ex = bits_i[30:23];
    fr = bits_i[22:0];
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) lz = 5'(22 - i);
    end
    zero = 1'b0;
    m = {1'b1, fr};
    e = 10'($signed({2'b0, ex}) - 10'sd150);
    if (bits_i[31] || (ex == 8'hFF && fr != 23'd0) || (ex == 8'd0 && fr == 23'd0)) begin
      zero = 1'b1;
      m = 24'd0;
      e = 10'sd0;
    end else if (ex == 8'hFF) begin
      m = MaxM;
      e = 10'(MaxE);
    end else if (ex == 8'd0) begin
      m = 24'({1'b0, fr} << (lz + 5'd1));
      e = 10'(-150) - 10'($signed({5'b0, lz}));
    end
    if (!zero && (e > 10'(MaxE) || (e == 10'(MaxE) && m > MaxM))) begin
      m = MaxM;
      e = 10'(MaxE);
    end
    chan_o.zero = zero;
    chan_o.m = m;
    chan_o.e = e;
  end
endmodule

>>> rtl/rgb9e5_lane.sv
module rgb9e5_lane
  import rgb9e5_pkg::*;
#(
  parameter int MANTISSA_WIDTH = 9
) (
  input  chan_t                      chan_i,
  input  logic signed [9:0]          t_i,
  output logic [MANTISSA_WIDTH:0]    mant_o,
  output logic                       big_o
);
  logic signed [10:0] q;
  logic [7:0] s;
  logic [25:0] sum;
  logic [25:0] shr;

  always_comb begin
    q = 11'($signed(chan_i.e)) + 11'($signed(t_i));
    s = (q < 0) ? 8'(-q) : 8'd0;
    sum = {2'b0, chan_i.m} + ((s != 8'd0) ? (26'd1 << (s - 8'd1)) : 26'd0);
    shr = (s >= 8'd25) ? 26'd0 : (sum >> s);
    big_o = 1'b0;
    mant_o = '0;
    if (!chan_i.zero) begin
      if (q >= 0) begin
        big_o = 1'b1;
      end else begin
        big_o = (shr > 26'((1 << (MANTISSA_WIDTH + 1)) - 1));
        mant_o = shr[MANTISSA_WIDTH:0];
      end
    end
  end
endmodule

>>> rtl/rgb9e5_merge.sv
module rgb9e5_merge
  import rgb9e5_pkg::*;
(
  input  chan_t a_i,
  input  chan_t b_i,
  output chan_t max_o
);
  logic gt;

  always_comb begin
    if (b_i.zero) gt = 1'b0;
    else if (a_i.zero) gt = 1'b1;
    else if (b_i.e != a_i.e) gt = $signed(b_i.e) > $signed(a_i.e);
    else gt = b_i.m > a_i.m;
    max_o = gt ? b_i : a_i;
  end
endmodule

>>> rtl/rgb9e5_shared_exponent_pack_top.sv
// RGB9E5 shared-exponent encoder.
// The in_ channel takes one beat per color: three IEEE-754 single bit
// patterns in tdata (red, green, blue, lowest first). The out_ channel
// returns the packed word in tdata and the overflow flag in tuser.
// Stage one decodes and clamps the three channels in parallel lanes and
// merges them into the largest channel and the shared exponent. Stage two
// rounds all three mantissas in parallel lanes at that exponent, raises the
// exponent when the largest mantissa rounds up to a full power of two, and
// registers the result.
// An accepted beat passes the stage one register and the output register
// before out_tvalid shows it. Throughput is one beat per cycle while the
// output register is empty or draining; stage one also loads when empty.
// When the receiver holds out_tready low, the pipeline holds and in_tready
// falls once both stages are full, so no beat is lost.
// Reset clears both stage valid flags; the payload registers are left as is.
module rgb9e5_shared_exponent_pack_top
  import rgb9e5_pkg::*;
#(
  parameter int MANTISSA_WIDTH = 9,
  parameter int EXPONENT_BIAS = 15,
  parameter int MAX_BIASED_EXPONENT = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // red_bits, green_bits, blue_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // packed_word
  output logic        out_tuser   // overflow_flag
);
  localparam int MW = MANTISSA_WIDTH;
  chan_t ch [3];
  chan_t mx01, mx;
  chan_t ch_r [3];
  chan_t mx_r;
  logic signed [9:0] ex1_r, ex1_nxt, ex, ex_raise, t1, t2;
  logic v1_r, v2_r;
  logic adv;
  logic [MW:0] m1 [3];
  logic [MW:0] m2 [3];
  logic [2:0]  bg1, bg2;
  logic [31:0] word_r, word_nxt;
  logic        ovf_r, ovf_nxt;
  logic signed [9:0] fl;

  for (genvar i = 0; i < 3; i++) begin : g_dec
    rgb9e5_decode #(
      .MANTISSA_WIDTH(MANTISSA_WIDTH), .EXPONENT_BIAS(EXPONENT_BIAS),
      .MAX_BIASED_EXPONENT(MAX_BIASED_EXPONENT)
    ) u_dec (.bits_i(in_tdata[32*i +: 32]), .chan_o(ch[i]));
  end

  rgb9e5_merge u_m0 (.a_i(ch[0]), .b_i(ch[1]), .max_o(mx01));
  rgb9e5_merge u_m1 (.a_i(mx01), .b_i(ch[2]), .max_o(mx));

  always_comb begin
    fl = mx.zero ? 10'(-EXPONENT_BIAS - 1) : 10'($signed(mx.e) + 10'sd23);
    if (fl < 10'(-EXPONENT_BIAS - 1)) fl = 10'(-EXPONENT_BIAS - 1);
    ex1_nxt = fl + 10'(1 + EXPONENT_BIAS);
  end

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv || !v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv) v2_r <= v1_r;
      if (in_tready) v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ch_r <= ch;
      mx_r <= mx;
      ex1_r <= ex1_nxt;
    end
    if (adv) begin
      word_r <= word_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign t1 = 10'(EXPONENT_BIAS + MW) - ex1_r;
  assign ex_raise = ex1_r + 10'sd1;
  assign t2 = t1 - 10'sd1;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rgb9e5_lane #(.MANTISSA_WIDTH(MW)) u_a (.chan_i(ch_r[i]), .t_i(t1), .mant_o(m1[i]),
                                            .big_o(bg1[i]));
    rgb9e5_lane #(.MANTISSA_WIDTH(MW)) u_b (.chan_i(ch_r[i]), .t_i(t2), .mant_o(m2[i]),
                                            .big_o(bg2[i]));
  end

  logic [MW:0] mxm;
  logic        mxbig, raise;
  rgb9e5_lane #(.MANTISSA_WIDTH(MW)) u_mx (.chan_i(mx_r), .t_i(t1), .mant_o(mxm),
                                           .big_o(mxbig));

  always_comb begin
    raise = !mxbig && mxm == (MW+1)'(1 << MW);
    ex = raise ? ex_raise : ex1_r;
    ovf_nxt = mxbig || (raise && ex_raise > 10'(MAX_BIASED_EXPONENT));
    word_nxt = 32'(ex) << (3 * MW);
    for (int i = 0; i < 3; i++) begin
      word_nxt = word_nxt | (32'(raise ? m2[i][MW-1:0] : m1[i][MW-1:0]) << (MW * i));
    end
    if (ovf_nxt) word_nxt = 32'hFFFF_FFFF;
    if (bg1 == 3'b111 && bg2 == 3'b111) word_nxt = word_nxt;
  end

  assign out_tvalid = v2_r;
  assign out_tdata = word_r;
  assign out_tuser = ovf_r;
endmodule

>>> rtl/rgb9e5_checker.sv
`include "rgb9e5_shared_exponent_pack_top_defines.svh"
module rgb9e5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  `RGB_ASSERT_IMPL(a_ovf_word, clk, rst_n, out_tvalid && out_tuser, out_tdata == 32'hFFFF_FFFF)
  `RGB_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RGB_ASSERT_IMPL(a_ready, clk, rst_n, out_tready, in_tready)
  `RGB_ASSERT_NEXT(a_lat, clk, rst_n, in_tvalid && in_tready && out_tready, ##1 out_tvalid)
endmodule

bind rgb9e5_shared_exponent_pack_top rgb9e5_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

>>> test/rgb9e5_shared_exponent_pack_top_tb.sv
`timescale 1ns / 100ps

module rgb9e5_shared_exponent_pack_top_tb;

  localparam int MW = 9;
  localparam int BIAS = 15;
  localparam int MAX_EXP = 31;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    longint m;
    longint e;
  } chan_val_t;

  typedef struct {
    logic [31:0] word;
    logic        ovf;
  } packed_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  packed_result_t expected_words[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  rgb9e5_shared_exponent_pack_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  function automatic chan_val_t clamp_top();
    chan_val_t c;
    c.m = ((64'd1 << MW) - 1) << (24 - MW);
    c.e = MAX_EXP - BIAS - 24;
    return c;
  endfunction

  function automatic bit chan_above(chan_val_t a, chan_val_t b);
    if (a.m == 0) return 1'b0;
    if (b.m == 0) return 1'b1;
    if (a.e != b.e) return a.e > b.e;
    return a.m > b.m;
  endfunction

  function automatic chan_val_t decode_float(logic [31:0] w);
    chan_val_t c;
    logic [7:0]  ex;
    logic [22:0] fr;
    ex = w[30:23];
    fr = w[22:0];
    c.m = 0;
    c.e = 0;
    if (w[31]) return c;
    if (ex == 8'hFF) begin
      if (fr != 0) return c;
      return clamp_top();
    end
    if (ex == 8'h00) begin
      if (fr == 0) return c;
      c.m = fr;
      c.e = -149;
      while (c.m < (64'd1 << 23)) begin
        c.m = c.m << 1;
        c.e = c.e - 1;
      end
    end else begin
      c.m = fr | (64'd1 << 23);
      c.e = longint'(ex) - 150;
    end
    if (chan_above(c, clamp_top())) return clamp_top();
    return c;
  endfunction

  function automatic longint round_at_scale(chan_val_t c, longint t);
    longint q;
    q = c.e + t;
    if (c.m == 0) return 0;
    if (q >= 0) begin
      if (q > 20) return 64'd1 << 44;
      return c.m << q;
    end
    if (-q >= 25) return 0;
    return (c.m + (64'd1 << (-q - 1))) >> (-q);
  endfunction

  function automatic packed_result_t pack_rgb9e5(logic [95:0] px);
    packed_result_t r;
    chan_val_t ch[3];
    chan_val_t mx;
    longint fl, ex, t, maxm;
    logic [63:0] word;
    for (int i = 0; i < 3; i++) ch[i] = decode_float(px[32*i +: 32]);
    mx = ch[0];
    if (chan_above(ch[1], mx)) mx = ch[1];
    if (chan_above(ch[2], mx)) mx = ch[2];
    fl = (mx.m != 0) ? mx.e + 23 : -BIAS - 1;
    if (fl < -BIAS - 1) fl = -BIAS - 1;
    ex = fl + 1 + BIAS;
    maxm = round_at_scale(mx, BIAS + MW - ex);
    r.word = 32'hFFFFFFFF;
    r.ovf = 1'b1;
    if (maxm == (64'd1 << MW)) begin
      ex = ex + 1;
      if (ex > MAX_EXP) return r;
    end else if (maxm > (64'd1 << MW) - 1) begin
      return r;
    end
    t = BIAS + MW - ex;
    word = '0;
    for (int i = 0; i < 3; i++)
      word |= (round_at_scale(ch[i], t) & ((64'd1 << MW) - 1)) << (MW * i);
    word |= 64'(ex[31:0]) << (3 * MW);
    r.word = word[31:0];
    r.ovf = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] random_channel();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: return {1'b0, 8'($urandom_range(100, 143)), 23'($urandom())};
      3: return {1'b0, 8'($urandom_range(140, 144)), 23'($urandom())};
      4: return {1'b0, 8'hFF, ($urandom_range(1) ? 23'($urandom()) : 23'd0)};
      5: return {1'b0, 8'd0, 23'($urandom())};
      6: return {1'b0, 8'($urandom_range(110, 145)), 23'h7FFFFF - 23'($urandom_range(300))};
      7: return {1'b1, 31'($urandom())};
      default: return {1'b0, 8'($urandom_range(60, 160)), 23'($urandom())};
    endcase
  endfunction

  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(pack_rgb9e5({b, g, r}));
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_words.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin
    packed_result_t w;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 32'h0);
      end else begin
        w = expected_words.pop_front();
        if (out_tdata !== w.word) report_mismatch("packed_word", out_tdata, w.word);
        if (out_tuser !== w.ovf)
          report_mismatch("overflow_flag", 32'(out_tuser), 32'(w.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_special_values();
    send_pixel(32'h00000000, 32'h00000000, 32'h00000000);
    send_pixel(32'h80000000, 32'hFF800000, 32'hBF800000);
    send_pixel(32'h7F800000, 32'h00000000, 32'h3F800000);
    send_pixel(32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF);
    send_pixel(32'h00000001, 32'h007FFFFF, 32'h00800000);
    send_pixel(32'h3F800000, 32'h3F000000, 32'h3E800000);
    send_pixel(32'h477F8000, 32'h477F8100, 32'h477F7F00);
    send_pixel(32'h7F7FFFFF, 32'h7149F2CA, 32'h47800000);
    send_pixel(32'h3FFFFFFF, 32'h3FFFC000, 32'h3FFF8000);
    send_pixel(32'h477FFFFF, 32'h477FC000, 32'h00000000);
    send_pixel(32'h37FFFFFF, 32'h37800000, 32'h377FFFFF);
    send_pixel(32'h38000000, 32'h33800000, 32'h00400000);
    send_pixel(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pixel(32'h00000000, 32'h477F8000, 32'h3F800000);
    send_pixel(32'h40490FDB, 32'h7F800000, 32'h42C80000);
    send_pixel(32'h477F8000, 32'h3D800000, 32'h3C000000);
    end_burst();
    wait_drained();
  endtask

  task automatic test_random_pixels(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send_pixel(random_channel(), random_channel(), random_channel());
    end_burst();
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 10; i++) send_pixel(random_channel(), random_channel(), random_channel());
      end_burst();
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_random_pixels(110, 0, 0);
    test_random_pixels(100, 84, 0);
    test_random_pixels(100, 0, 84);
    test_random_pixels(110, 11, 11);
    test_pause_until_drained();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
